// File: rtl/mlptc_pkg.sv
package mlptc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_LAYERS_DEF = 4;
    localparam int MAX_NODES_DEF  = 16;
    localparam int VALUE_BITS_DEF = 16;

    // Fixed-point format
    localparam int FRAC  = 12;
    localparam int ONE_Q = 4096;

    // Register reset values
    localparam logic [2:0]  LAYER_COUNT_RST = 3'd3;
    localparam logic [4:0]  NODES_IN_RST    = 5'd4;
    localparam logic [4:0]  NODES_A_RST     = 5'd8;
    localparam logic [4:0]  NODES_B_RST     = 5'd3;
    localparam logic [4:0]  NODES_D_RST     = 5'd3;
    localparam logic [15:0] LRATE_RST       = 16'd6554;

    typedef enum logic [1:0] {
        OP_LOAD_W  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_PREDICT = 2'd2,
        OP_TRAIN   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_LAYER_COUNT = 3'd0,
        CFG_NODES_IN    = 3'd1,
        CFG_NODES_A     = 3'd2,
        CFG_NODES_B     = 3'd3,
        CFG_NODES_D     = 3'd4,
        CFG_LRATE       = 3'd5
    } t_cfg_idx;

    // Sequencer states: forward, output deltas, hidden deltas, update
    typedef enum logic [5:0] {
        S_IDLE,
        S_F_RD, S_F_LD, S_F_SIG, S_F_MUL, S_F_ACC, S_F_BRD, S_F_BLD, S_F_WR,
        S_O_RD, S_O_LD, S_O_S1, S_O_S2, S_O_WR,
        S_H_RD, S_H_MUL, S_H_ACC, S_H_NRD, S_H_NLD, S_H_S1, S_H_S2, S_H_WR,
        S_U_DRD, S_U_DLD, S_U_RD, S_U_LD, S_U_SIG, S_U_MUL1, S_U_T, S_U_MUL2,
        S_U_WR, S_U_BRD, S_U_BMUL, S_U_BWR,
        S_FIN
    } t_state;

    // Sigmoid knots, Q0.16, x = 0.0 .. 8.0 in steps of 0.5
    function automatic logic [16:0] sig_tab(input logic [4:0] idx);
        logic [16:0] y;
        case (idx)
            5'd0:    y = 17'd32768;
            5'd1:    y = 17'd40793;
            5'd2:    y = 17'd47911;
            5'd3:    y = 17'd53581;
            5'd4:    y = 17'd57724;
            5'd5:    y = 17'd60565;
            5'd6:    y = 17'd62428;
            5'd7:    y = 17'd63615;
            5'd8:    y = 17'd64357;
            5'd9:    y = 17'd64816;
            5'd10:   y = 17'd65097;
            5'd11:   y = 17'd65269;
            5'd12:   y = 17'd65374;
            5'd13:   y = 17'd65438;
            5'd14:   y = 17'd65476;
            5'd15:   y = 17'd65500;
            default: y = 17'd65514;
        endcase
        return y;
    endfunction

endpackage

// File: rtl/mlptc_if.sv
// Request channel: one load or feature
interface mlptc_in_if #(parameter int VALUE_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic [1:0]                   layer_sel;
    logic [7:0]                   slot;
    logic signed [VALUE_BITS-1:0] value;
    logic [3:0]                   label;
    logic                         last;

    modport source (output valid, op, layer_sel, slot, value, label, last, input ready);
    modport sink   (input valid, op, layer_sel, slot, value, label, last, output ready);
endinterface

// Result channel: class and match flag
interface mlptc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] prediction;
    logic       label_matched;

    modport source (output valid, prediction, label_matched, input ready);
    modport sink   (input valid, prediction, label_matched, output ready);
endinterface

// Register write channel
interface mlptc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/mlptc_act.sv
// Two-stage activation unit: the sigmoid is registered, and s*(1-s) is registered from it
module mlptc_act #(
    parameter int VALUE_BITS = mlptc_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic signed [VALUE_BITS-1:0] i_x,
    output logic [12:0]                  o_sig,
    output logic [10:0]                  o_sigd
);
    import mlptc_pkg::*;

    localparam int AW = VALUE_BITS + 1;

    logic signed [AW-1:0] x_ext;
    logic [AW-1:0]        mag;
    logic [31:0]          mag32;
    logic [3:0]           seg;
    logic [10:0]          frac;
    logic [16:0]          t_lo;
    logic [16:0]          t_hi;
    logic [12:0]          diff;
    logic [23:0]          interp;
    logic [16:0]          y_pos;
    logic [16:0]          y;
    logic [17:0]          y_rnd;
    logic [25:0]          dprod;
    logic [25:0]          drnd;
    logic [12:0]          r_sig;
    logic [10:0]          r_sigd;

    // Magnitude, segment and interpolation
    always_comb begin
        x_ext  = AW'(i_x);
        mag    = (x_ext < 0) ? AW'(-x_ext) : AW'(x_ext);
        mag32  = 32'(mag);
        seg    = mag32[14:11];
        frac   = mag32[10:0];
        t_lo   = sig_tab({1'b0, seg});
        t_hi   = sig_tab(5'({1'b0, seg}) + 5'd1);
        diff   = 13'(t_hi - t_lo);
        interp = 24'(diff) * 24'(frac) + 24'd1024;
        y_pos  = (mag32 >= 32'd32768) ? sig_tab(5'd16) : t_lo + 17'(interp >> 11);
        y      = (i_x < 0) ? 17'(17'd65536 - y_pos) : y_pos;
        y_rnd  = 18'(y) + 18'd8;
    end

    // Derivative from the registered sigmoid
    always_comb begin
        dprod = 26'(r_sig) * 26'(13'd4096 - r_sig);
        drnd  = dprod + 26'd2048;
    end

    always_ff @(posedge i_clk) begin
        r_sig  <= y_rnd[16:4];
        r_sigd <= drnd[22:12];
    end

    assign o_sig  = r_sig;
    assign o_sigd = r_sigd;

endmodule

// File: rtl/mlp_train_and_classify.sv
// Channel   Direction  Payload                                  Accepted when
// i_in      in         op, layer_sel, slot, value, label, last  valid && ready
// o_res     out        prediction, label_matched                valid && ready
// i_cfg     in         index, data                              valid && ready
//
// A load or a feature without last is taken in the idle state. A last feature
// runs the sequencer over the weight memory, one read-modify-write at a time:
// the forward pass, then for training the output deltas, the hidden deltas and
// the weight and bias update. Each memory has one read and one write port.
// Reset is synchronous; the stores hold no reset value. A finished result
// waits in its own register while new loads are accepted.
module mlp_train_and_classify #(
    parameter int MAX_LAYERS = mlptc_pkg::MAX_LAYERS_DEF,
    parameter int MAX_NODES  = mlptc_pkg::MAX_NODES_DEF,
    parameter int VALUE_BITS = mlptc_pkg::VALUE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mlptc_in_if.sink      i_in,
    mlptc_out_if.source   o_res,
    mlptc_cfg_if.sink     i_cfg
);
    import mlptc_pkg::*;

    localparam int VB     = VALUE_BITS;
    localparam int MN     = MAX_NODES;
    localparam int NIW    = $clog2(MAX_NODES);
    localparam int CW     = $clog2(MAX_NODES + 1);
    localparam int BANK   = MN * MN;
    localparam int WDEPTH = (MAX_LAYERS - 1) * BANK;
    localparam int WAW    = $clog2(WDEPTH);
    localparam int NDEPTH = MAX_LAYERS * MN;
    localparam int NAW    = $clog2(NDEPTH);
    localparam int MAXL   = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
    localparam int XW     = (VB > 14) ? VB : 14;
    localparam int BW     = (XW > 17) ? XW : 17;
    localparam int PW     = XW + BW;
    localparam logic signed [63:0] VMAX    = (64'sd1 <<< (VB - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN    = -VMAX - 64'sd1;
    localparam logic signed [63:0] ACC_LIM = 64'sd1 <<< 61;

    // ---------------- helpers ----------------
    function automatic logic signed [VB-1:0] sat_v(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > VMAX) ? VMAX : ((v < VMIN) ? VMIN : v);
        return VB'(c);
    endfunction

    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [63:0] acc_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        return (s > ACC_LIM) ? ACC_LIM : ((s < -ACC_LIM) ? -ACC_LIM : s);
    endfunction

    function automatic logic [CW-1:0] clampn(input logic [4:0] n);
        logic [CW-1:0] c;
        if (n == 5'd0) begin
            c = CW'(1);
        end else if (32'(n) > MN) begin
            c = CW'(MN);
        end else begin
            c = CW'(n);
        end
        return c;
    endfunction

    function automatic logic [NAW-1:0] naddr(input logic [1:0] l, input logic [NIW-1:0] i);
        return NAW'(32'(l) * MN + 32'(i));
    endfunction

    function automatic logic [WAW-1:0] waddr(input logic [1:0] lm1, input logic [NIW-1:0] row,
                                             input logic [NIW-1:0] col, input logic [CW-1:0] n);
        return WAW'(32'(lm1) * BANK + 32'(row) * 32'(n) + 32'(col));
    endfunction

    // ---------------- configuration ----------------
    logic [2:0]  r_layer_count;
    logic [4:0]  r_nodes_in;
    logic [4:0]  r_nodes_a;
    logic [4:0]  r_nodes_b;
    logic [4:0]  r_nodes_d;
    logic [15:0] r_lr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= LAYER_COUNT_RST;
            r_nodes_in    <= NODES_IN_RST;
            r_nodes_a     <= NODES_A_RST;
            r_nodes_b     <= NODES_B_RST;
            r_nodes_d     <= NODES_D_RST;
            r_lr          <= LRATE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_LAYER_COUNT: r_layer_count <= i_cfg.data[2:0];
                CFG_NODES_IN:    r_nodes_in    <= i_cfg.data[4:0];
                CFG_NODES_A:     r_nodes_a     <= i_cfg.data[4:0];
                CFG_NODES_B:     r_nodes_b     <= i_cfg.data[4:0];
                CFG_NODES_D:     r_nodes_d     <= i_cfg.data[4:0];
                CFG_LRATE:       r_lr          <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // Clamped topology
    logic [CW-1:0] cnt0, cnt1, cnt2, cnt3;
    logic [2:0]    l_tot;
    logic [1:0]    lo;

    always_comb begin
        cnt0  = clampn(r_nodes_in);
        cnt1  = clampn(r_nodes_a);
        cnt2  = clampn(r_nodes_b);
        cnt3  = clampn(r_nodes_d);
        if (r_layer_count < 3'd2) begin
            l_tot = 3'd2;
        end else if (32'(r_layer_count) > MAXL) begin
            l_tot = 3'(MAXL);
        end else begin
            l_tot = r_layer_count;
        end
        lo = 2'(l_tot - 3'd1);
    end

    function automatic logic [CW-1:0] cnt_of(input logic [1:0] l);
        logic [CW-1:0] c;
        case (l)
            2'd0:    c = cnt0;
            2'd1:    c = cnt1;
            2'd2:    c = cnt2;
            default: c = cnt3;
        endcase
        return c;
    endfunction

    // ---------------- state ----------------
    t_state                r_state, n_state;
    logic [1:0]            r_l;
    logic [NIW-1:0]        r_j;
    logic [NIW-1:0]        r_k;
    logic signed [63:0]    r_acc;
    logic signed [XW-1:0]  r_x;
    logic signed [PW-1:0]  r_prod;
    logic signed [VB-1:0]  r_err;
    logic signed [VB-1:0]  r_d;
    logic signed [VB-1:0]  r_t;
    logic signed [VB-1:0]  r_best;
    logic [NIW-1:0]        r_pred;
    logic                  r_train;
    logic [3:0]            r_label;
    logic [MN-1:0]         r_fvalid;
    logic                  r_out_valid;
    logic [3:0]            r_out_pred;
    logic                  r_out_match;

    // Memories and their ports
    logic signed [VB-1:0] wt_mem [WDEPTH];
    logic signed [VB-1:0] bs_mem [NDEPTH];
    logic signed [VB-1:0] nd_mem [NDEPTH];
    logic signed [VB-1:0] dl_mem [NDEPTH];
    logic signed [VB-1:0] r_wt_q, r_bs_q, r_nd_q, r_dl_q;
    logic                 wt_re, wt_we, bs_re, bs_we, nd_re, nd_we, dl_re, dl_we;
    logic [WAW-1:0]       wt_ra, wt_wa;
    logic [NAW-1:0]       bs_ra, bs_wa, nd_ra, nd_wa, dl_ra, dl_wa;
    logic signed [VB-1:0] wt_wd, bs_wd, nd_wd, dl_wd;

    always_ff @(posedge i_clk) begin
        if (wt_we) wt_mem[wt_wa] <= wt_wd;
        if (wt_re) r_wt_q <= wt_mem[wt_ra];
    end
    always_ff @(posedge i_clk) begin
        if (bs_we) bs_mem[bs_wa] <= bs_wd;
        if (bs_re) r_bs_q <= bs_mem[bs_ra];
    end
    always_ff @(posedge i_clk) begin
        if (nd_we) nd_mem[nd_wa] <= nd_wd;
        if (nd_re) r_nd_q <= nd_mem[nd_ra];
    end
    always_ff @(posedge i_clk) begin
        if (dl_we) dl_mem[dl_wa] <= dl_wd;
        if (dl_re) r_dl_q <= dl_mem[dl_ra];
    end

    // Activation unit on the node read data
    logic [12:0] sig;
    logic [10:0] sigd;

    mlptc_act #(.VALUE_BITS(VB)) u_act (
        .i_clk  (i_clk),
        .i_x    (r_nd_q),
        .o_sig  (sig),
        .o_sigd (sigd)
    );

    // ---------------- datapath values ----------------
    logic                  in_acc;
    logic                  is_feat;
    logic [1:0]            lm1;
    logic [CW-1:0]         nl, nr;
    logic                  k_last_nl, k_last_nr, j_last_nl, j_last_nr, j_last_out;
    logic signed [63:0]    prod64;
    logic signed [VB-1:0]  fwd_val, prod_val, upd_w, upd_b, err_o;
    logic signed [VB-1:0]  node_x;
    logic signed [XW-1:0]  sig_x;
    logic signed [BW-1:0]  sigd_b, lr_b;
    logic signed [XW-1:0]  mul_a;
    logic signed [BW-1:0]  mul_b;
    logic                  mul_en;

    always_comb begin
        in_acc     = i_in.valid && i_in.ready;
        is_feat    = (i_in.op == OP_PREDICT) || (i_in.op == OP_TRAIN);
        lm1        = r_l - 2'd1;
        nl         = cnt_of(lm1);
        nr         = cnt_of(r_l);
        k_last_nl  = (CW'(r_k) + CW'(1)) == nl;
        k_last_nr  = (CW'(r_k) + CW'(1)) == nr;
        j_last_nl  = (CW'(r_j) + CW'(1)) == nl;
        j_last_nr  = (CW'(r_j) + CW'(1)) == nr;
        j_last_out = (CW'(r_j) + CW'(1)) == cnt_of(lo);
        prod64     = 64'(r_prod);
        fwd_val    = sat_v(rnd_sh(r_acc, FRAC));
        prod_val   = sat_v(rnd_sh(prod64, FRAC));
        upd_w      = sat_v(64'(r_wt_q) + rnd_sh(prod64, 16));
        upd_b      = sat_v(64'(r_bs_q) + rnd_sh(prod64, 16));
        // features never written this sample read zero
        node_x     = (r_l == 2'd1 && !r_fvalid[r_k]) ? '0 : r_nd_q;
        sig_x      = XW'(signed'({1'b0, sig}));
        sigd_b     = BW'(signed'({1'b0, sigd}));
        lr_b       = BW'(signed'({1'b0, r_lr}));
        err_o      = sat_v(((8'(r_label) == 8'(r_j)) ? 64'sd4096 : 64'sd0)
                           - 64'(signed'({1'b0, sig})));
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc && is_feat && i_in.last) n_state = S_F_RD;
            S_F_RD:   n_state = S_F_LD;
            S_F_LD:   n_state = (r_l == 2'd1) ? S_F_MUL : S_F_SIG;
            S_F_SIG:  n_state = S_F_MUL;
            S_F_MUL:  n_state = S_F_ACC;
            S_F_ACC:  n_state = k_last_nl ? S_F_BRD : S_F_RD;
            S_F_BRD:  n_state = S_F_BLD;
            S_F_BLD:  n_state = S_F_WR;
            S_F_WR: begin
                if (j_last_nr && r_l == lo) begin
                    n_state = r_train ? S_O_RD : S_FIN;
                end else begin
                    n_state = S_F_RD;
                end
            end
            S_O_RD:   n_state = S_O_LD;
            S_O_LD:   n_state = S_O_S1;
            S_O_S1:   n_state = S_O_S2;
            S_O_S2:   n_state = S_O_WR;
            S_O_WR: begin
                if (j_last_out) begin
                    n_state = (lo > 2'd1) ? S_H_RD : S_U_DRD;
                end else begin
                    n_state = S_O_RD;
                end
            end
            S_H_RD:   n_state = S_H_MUL;
            S_H_MUL:  n_state = S_H_ACC;
            S_H_ACC:  n_state = k_last_nr ? S_H_NRD : S_H_RD;
            S_H_NRD:  n_state = S_H_NLD;
            S_H_NLD:  n_state = S_H_S1;
            S_H_S1:   n_state = S_H_S2;
            S_H_S2:   n_state = S_H_WR;
            S_H_WR:   n_state = (j_last_nl && r_l == 2'd2) ? S_U_DRD : S_H_RD;
            S_U_DRD:  n_state = S_U_DLD;
            S_U_DLD:  n_state = S_U_RD;
            S_U_RD:   n_state = S_U_LD;
            S_U_LD:   n_state = (r_l == 2'd1) ? S_U_MUL1 : S_U_SIG;
            S_U_SIG:  n_state = S_U_MUL1;
            S_U_MUL1: n_state = S_U_T;
            S_U_T:    n_state = S_U_MUL2;
            S_U_MUL2: n_state = S_U_WR;
            S_U_WR:   n_state = k_last_nl ? S_U_BRD : S_U_RD;
            S_U_BRD:  n_state = S_U_BMUL;
            S_U_BMUL: n_state = S_U_BWR;
            S_U_BWR:  n_state = (j_last_nr && r_l == 2'd1) ? S_FIN : S_U_DRD;
            S_FIN:    if (!r_out_valid) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------- memory ports and multiplier operands ----------------
    always_comb begin
        wt_re = 1'b0; wt_we = 1'b0; wt_ra = '0; wt_wa = '0; wt_wd = '0;
        bs_re = 1'b0; bs_we = 1'b0; bs_ra = '0; bs_wa = '0; bs_wd = '0;
        nd_re = 1'b0; nd_we = 1'b0; nd_ra = '0; nd_wa = '0; nd_wd = '0;
        dl_re = 1'b0; dl_we = 1'b0; dl_ra = '0; dl_wa = '0; dl_wd = '0;
        mul_en = 1'b0; mul_a = '0; mul_b = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.op == OP_LOAD_W) begin
                        wt_we = (32'(i_in.layer_sel) < MAX_LAYERS - 1) && (32'(i_in.slot) < BANK);
                        wt_wa = WAW'(32'(i_in.layer_sel) * BANK + 32'(i_in.slot));
                        wt_wd = i_in.value;
                    end else if (i_in.op == OP_LOAD_B) begin
                        bs_we = (32'(i_in.layer_sel) < MAX_LAYERS) && (32'(i_in.slot) < MN);
                        bs_wa = NAW'(32'(i_in.layer_sel) * MN + 32'(i_in.slot));
                        bs_wd = i_in.value;
                    end else begin
                        nd_we = 32'(i_in.slot) < 32'(cnt0);
                        nd_wa = naddr(2'd0, NIW'(i_in.slot));
                        nd_wd = i_in.value;
                    end
                end
            end
            S_F_RD: begin
                nd_re = 1'b1; nd_ra = naddr(lm1, r_k);
                wt_re = 1'b1; wt_ra = waddr(lm1, r_j, r_k, nl);
            end
            S_F_MUL: begin
                mul_en = 1'b1; mul_a = r_x; mul_b = BW'(r_wt_q);
            end
            S_F_BRD: begin
                bs_re = 1'b1; bs_ra = naddr(r_l, r_j);
            end
            S_F_WR: begin
                nd_we = 1'b1; nd_wa = naddr(r_l, r_j); nd_wd = fwd_val;
            end
            S_O_RD: begin
                nd_re = 1'b1; nd_ra = naddr(r_l, r_j);
            end
            S_O_S2, S_H_S2: begin
                mul_en = 1'b1; mul_a = XW'(r_err); mul_b = sigd_b;
            end
            S_O_WR: begin
                dl_we = 1'b1; dl_wa = naddr(r_l, r_j); dl_wd = prod_val;
            end
            S_H_RD: begin
                wt_re = 1'b1; wt_ra = waddr(lm1, r_k, r_j, nl);
                dl_re = 1'b1; dl_ra = naddr(r_l, r_k);
            end
            S_H_MUL: begin
                mul_en = 1'b1; mul_a = XW'(r_wt_q); mul_b = BW'(r_dl_q);
            end
            S_H_NRD: begin
                nd_re = 1'b1; nd_ra = naddr(lm1, r_j);
            end
            S_H_WR: begin
                dl_we = 1'b1; dl_wa = naddr(lm1, r_j); dl_wd = prod_val;
            end
            S_U_DRD: begin
                dl_re = 1'b1; dl_ra = naddr(r_l, r_j);
            end
            S_U_RD: begin
                nd_re = 1'b1; nd_ra = naddr(lm1, r_k);
                wt_re = 1'b1; wt_ra = waddr(lm1, r_j, r_k, nl);
            end
            S_U_MUL1: begin
                mul_en = 1'b1; mul_a = XW'(r_d); mul_b = BW'(r_x);
            end
            S_U_MUL2: begin
                mul_en = 1'b1; mul_a = XW'(r_t); mul_b = lr_b;
            end
            S_U_WR: begin
                wt_we = 1'b1; wt_wa = waddr(lm1, r_j, r_k, nl); wt_wd = upd_w;
            end
            S_U_BRD: begin
                bs_re = 1'b1; bs_ra = naddr(r_l, r_j);
            end
            S_U_BMUL: begin
                mul_en = 1'b1; mul_a = XW'(r_d); mul_b = lr_b;
            end
            S_U_BWR: begin
                bs_we = 1'b1; bs_wa = naddr(r_l, r_j); bs_wd = upd_b;
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fvalid    <= '0;
        end else begin
            r_state <= n_state;
            if (o_res.valid && o_res.ready) r_out_valid <= 1'b0;
            if (r_state == S_IDLE && in_acc && is_feat && 32'(i_in.slot) < 32'(cnt0)) begin
                r_fvalid[NIW'(i_in.slot)] <= 1'b1;
            end
            if (r_state == S_FIN && !r_out_valid) begin
                r_out_valid <= 1'b1;
                r_fvalid    <= '0;
            end
        end
    end

    // ---------------- sequencer datapath ----------------
    always_ff @(posedge i_clk) begin
        if (mul_en) r_prod <= PW'(mul_a) * PW'(mul_b);
        case (r_state)
            S_IDLE: begin
                if (in_acc && is_feat && i_in.last) begin
                    r_l     <= 2'd1;
                    r_j     <= '0;
                    r_k     <= '0;
                    r_acc   <= '0;
                    r_train <= (i_in.op == OP_TRAIN);
                    r_label <= i_in.label;
                end
            end
            S_F_LD:  r_x <= XW'(node_x);
            S_F_SIG: r_x <= sig_x;
            S_F_ACC, S_H_ACC: begin
                r_acc <= acc_add(r_acc, prod64);
                if (!((r_state == S_F_ACC) ? k_last_nl : k_last_nr)) r_k <= r_k + NIW'(1);
            end
            S_F_BLD: r_acc <= acc_add(r_acc, 64'(r_bs_q) <<< FRAC);
            S_F_WR: begin
                r_acc <= '0;
                r_k   <= '0;
                // argmax over the output layer, first maximum kept
                if (r_l == lo && (r_j == '0 || fwd_val > r_best)) begin
                    r_best <= fwd_val;
                    r_pred <= r_j;
                end
                if (j_last_nr) begin
                    r_j <= '0;
                    if (r_l != lo) r_l <= r_l + 2'd1;
                end else begin
                    r_j <= r_j + NIW'(1);
                end
            end
            S_O_S1:  r_err <= err_o;
            S_O_WR:  r_j <= j_last_out ? '0 : r_j + NIW'(1);
            S_H_NLD: r_err <= fwd_val;
            S_H_WR: begin
                r_acc <= '0;
                r_k   <= '0;
                if (j_last_nl) begin
                    r_j <= '0;
                    r_l <= (r_l == 2'd2) ? lo : r_l - 2'd1;
                end else begin
                    r_j <= r_j + NIW'(1);
                end
            end
            S_U_DLD: r_d <= r_dl_q;
            S_U_LD:  r_x <= XW'(node_x);
            S_U_SIG: r_x <= sig_x;
            S_U_T:   r_t <= prod_val;
            S_U_WR:  r_k <= k_last_nl ? '0 : r_k + NIW'(1);
            S_U_BWR: begin
                if (j_last_nr) begin
                    r_j <= '0;
                    r_l <= r_l - 2'd1;
                end else begin
                    r_j <= r_j + NIW'(1);
                end
            end
            S_FIN: begin
                if (!r_out_valid) begin
                    r_out_pred  <= 4'(r_pred);
                    r_out_match <= (8'(r_pred) == 8'(r_label));
                end
            end
            default: ;
        endcase
    end

    // ---------------- ports ----------------
    assign i_in.ready          = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.prediction    = r_out_pred;
    assign o_res.label_matched = r_out_match;

    // ---------------- checks ----------------
    a_res_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside the final state");

    a_wt_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wt_we |-> (r_state == S_IDLE || r_state == S_U_WR))
        else $error("weight write from an unexpected state");

    a_fvalid_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !r_out_valid) |=> (r_fvalid == '0))
        else $error("feature valid bits not cleared at end of sample");

    a_delta_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dl_we |-> (r_state == S_O_WR || r_state == S_H_WR))
        else $error("delta write from an unexpected state");

endmodule

// File: tb/mlptc_checker.sv
// Watches the three channels of mlp_train_and_classify, keeps its own copy of the
// network and the registers, predicts each classification and compares it.
module mlptc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mlptc_in_if  in_ch,
    mlptc_out_if res_ch,
    mlptc_cfg_if cfg_ch,
    output int   o_errors,
    output int   o_pending,
    output int   o_results
);
    import mlptc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES  = 16;
    localparam int BANK_W = NODES * NODES;
    localparam longint ACC_CAP = longint'(1) << 61;

    typedef struct packed {
        logic [3:0] prediction;
        logic       label_matched;
    } t_class_result;

    // Sigmoid knots, Q0.16, steps of 0.5
    localparam longint SIG_KNOT [0:16] = '{
        32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
        64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
    };

    t_class_result class_q[$];

    longint weights [0:3*BANK_W-1];
    longint biases  [0:4*NODES-1];
    longint acts    [0:4*NODES-1];
    longint deltas  [0:4*NODES-1];

    logic [2:0]  layer_cnt_r;
    logic [4:0]  n_in_r, n_a_r, n_b_r, n_d_r;
    logic [15:0] rate_r;

    function automatic longint sat_q(longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic longint acc_sum(longint a, longint b);
        longint s;
        s = a + b;
        return s > ACC_CAP ? ACC_CAP : (s < -ACC_CAP ? -ACC_CAP : s);
    endfunction

    // round half up, arithmetic shift
    function automatic longint round_sh(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sigmoid_q(longint x);
        longint a, y, i, f;
        a = x < 0 ? -x : x;
        if (a >= 32768) begin
            y = SIG_KNOT[16];
        end else begin
            i = a >> 11;
            f = a & 2047;
            y = SIG_KNOT[i] + (((SIG_KNOT[i+1] - SIG_KNOT[i]) * f + 1024) >> 11);
        end
        if (x < 0) begin
            y = 65536 - y;
        end
        return (y + 8) >> 4;
    endfunction

    function automatic longint sigmoid_slope(longint x);
        longint s;
        s = sigmoid_q(x);
        return round_sh(s * (ONE_Q - s), FRAC);
    endfunction

    function automatic int clamp_nodes(logic [4:0] n);
        return n < 1 ? 1 : (n > NODES ? NODES : int'(n));
    endfunction

    // Apply one accepted request to the network copy; queue a result on last
    task automatic apply_request(t_op op, int lsel, int slot, longint val,
                                 int label, logic last);
        int cnt [0:3];
        int nl_layers, l, j, k, nl, nr, pred;
        longint acc, x, err, d, t;
        cnt[0] = clamp_nodes(n_in_r);
        cnt[1] = clamp_nodes(n_a_r);
        cnt[2] = clamp_nodes(n_b_r);
        cnt[3] = clamp_nodes(n_d_r);
        nl_layers = layer_cnt_r < 2 ? 2 : (layer_cnt_r > 4 ? 4 : int'(layer_cnt_r));
        pred = 0;

        case (op)
            OP_LOAD_W: begin
                if (lsel < 3) weights[lsel*BANK_W + slot] = val;
                return;
            end
            OP_LOAD_B: begin
                if (slot < NODES) biases[lsel*NODES + slot] = val;
                return;
            end
            default: ;
        endcase
        if (slot < cnt[0]) acts[slot] = val;
        if (!last) return;

        // forward pass
        for (l = 1; l < nl_layers; l++) begin
            nl = cnt[l-1];
            nr = cnt[l];
            for (j = 0; j < nr; j++) begin
                acc = 0;
                for (k = 0; k < nl; k++) begin
                    x = acts[(l-1)*NODES + k];
                    if (l > 1) x = sigmoid_q(x);
                    acc = acc_sum(acc, x * weights[(l-1)*BANK_W + j*nl + k]);
                end
                acc = acc_sum(acc, biases[l*NODES + j] * ONE_Q);
                acts[l*NODES + j] = sat_q(round_sh(acc, FRAC));
            end
        end
        for (j = 1; j < cnt[nl_layers-1]; j++) begin
            if (acts[(nl_layers-1)*NODES + j] > acts[(nl_layers-1)*NODES + pred]) pred = j;
        end

        if (op == OP_TRAIN) begin
            // output deltas from one-hot targets
            l = nl_layers - 1;
            for (j = 0; j < cnt[l]; j++) begin
                x = acts[l*NODES + j];
                err = sat_q((label == j ? ONE_Q : 0) - sigmoid_q(x));
                deltas[l*NODES + j] = sat_q(round_sh(err * sigmoid_slope(x), FRAC));
            end
            // hidden deltas
            for (l = nl_layers - 1; l > 1; l--) begin
                nl = cnt[l-1];
                nr = cnt[l];
                for (j = 0; j < nl; j++) begin
                    acc = 0;
                    for (k = 0; k < nr; k++) begin
                        acc = acc_sum(acc, weights[(l-1)*BANK_W + k*nl + j]
                                           * deltas[l*NODES + k]);
                    end
                    err = sat_q(round_sh(acc, FRAC));
                    deltas[(l-1)*NODES + j] = sat_q(round_sh(
                        err * sigmoid_slope(acts[(l-1)*NODES + j]), FRAC));
                end
            end
            // SGD step on weights and biases
            for (l = nl_layers - 1; l > 0; l--) begin
                nl = cnt[l-1];
                nr = cnt[l];
                for (j = 0; j < nr; j++) begin
                    d = deltas[l*NODES + j];
                    for (k = 0; k < nl; k++) begin
                        x = acts[(l-1)*NODES + k];
                        if (l > 1) x = sigmoid_q(x);
                        t = sat_q(round_sh(d * x, FRAC));
                        weights[(l-1)*BANK_W + j*nl + k] = sat_q(
                            weights[(l-1)*BANK_W + j*nl + k] + round_sh(t * rate_r, 16));
                    end
                    biases[l*NODES + j] = sat_q(biases[l*NODES + j]
                                                + round_sh(d * rate_r, 16));
                end
            end
        end

        foreach (acts[i]) acts[i] = 0;
        foreach (deltas[i]) deltas[i] = 0;
        class_q.push_back('{prediction: 4'(pred), label_matched: pred == label});
    endtask

    always @(posedge i_clk) begin
        t_class_result exp_r;
        if (!i_rst_n) begin
            layer_cnt_r = LAYER_COUNT_RST;
            n_in_r = NODES_IN_RST;
            n_a_r = NODES_A_RST;
            n_b_r = NODES_B_RST;
            n_d_r = NODES_D_RST;
            rate_r = LRATE_RST;
            foreach (acts[i]) acts[i] = 0;
            foreach (deltas[i]) deltas[i] = 0;
            class_q.delete();
            o_errors = 0;
            o_results = 0;
        end else begin
            // register writes
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_cfg_idx'(cfg_ch.index))
                    CFG_LAYER_COUNT: layer_cnt_r = cfg_ch.data[2:0];
                    CFG_NODES_IN:    n_in_r = cfg_ch.data[4:0];
                    CFG_NODES_A:     n_a_r = cfg_ch.data[4:0];
                    CFG_NODES_B:     n_b_r = cfg_ch.data[4:0];
                    CFG_NODES_D:     n_d_r = cfg_ch.data[4:0];
                    CFG_LRATE:       rate_r = cfg_ch.data;
                    default: ;
                endcase
            end
            // accepted request
            if (in_ch.valid && in_ch.ready) begin
                apply_request(t_op'(in_ch.op), int'(in_ch.layer_sel), int'(in_ch.slot),
                              longint'($signed(in_ch.value)), int'(in_ch.label),
                              in_ch.last);
            end
            // accepted result
            if (res_ch.valid && res_ch.ready) begin
                o_results++;
                if (class_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected result prediction=%0d matched=%0b",
                                 $realtime, res_ch.prediction, res_ch.label_matched);
                end else begin
                    exp_r = class_q.pop_front();
                    if (exp_r.prediction !== res_ch.prediction
                        || exp_r.label_matched !== res_ch.label_matched) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: result %0d mismatch: expected %0d/%0b got %0d/%0b",
                                     $realtime, o_results, exp_r.prediction,
                                     exp_r.label_matched, res_ch.prediction,
                                     res_ch.label_matched);
                    end
                end
            end
        end
        o_pending = class_q.size();
    end
endmodule

// File: tb/mlp_train_and_classify_test.sv
module mlp_train_and_classify_test;
    import mlptc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 4_000_000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, results;
    int   requests, settings, burst_left;
    longint cycles;
    int   cnt [0:3];
    int   layers;

    mlptc_in_if #(.VALUE_BITS(16)) in_ch ();
    mlptc_out_if res_ch ();
    mlptc_cfg_if cfg_ch ();

    mlp_train_and_classify dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_res(res_ch), .i_cfg(cfg_ch)
    );

    mlptc_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .res_ch(res_ch), .cfg_ch(cfg_ch),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side stalls, pattern changes every stretch
    int stall_mode, stall_len;
    initial begin
        stall_mode = 0;
        stall_len = 0;
    end
    always @(posedge i_clk) begin
        if (stall_len == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_len = $urandom_range(10, 300);
        end
        stall_len--;
        case (stall_mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= $urandom_range(0, 1);
            default: res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // One request, sent in bursts with random gaps
    task automatic put(t_op op, int lsel, int slot, logic [15:0] val,
                       int label, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.layer_sel <= 2'(lsel);
        in_ch.slot      <= 8'(slot);
        in_ch.value     <= val;
        in_ch.label     <= 4'(label);
        in_ch.last      <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        requests++;
    endtask

    // Hold off until every classification is back, then let loads settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int clamp_n(int n);
        return n < 1 ? 1 : (n > 16 ? 16 : n);
    endfunction

    task automatic configure(int lc, int ni, int na, int nb, int nd, int lr);
        drain();
        write_reg(CFG_LAYER_COUNT, 16'(lc));
        write_reg(CFG_NODES_IN, 16'(ni));
        write_reg(CFG_NODES_A, 16'(na));
        write_reg(CFG_NODES_B, 16'(nb));
        write_reg(CFG_NODES_D, 16'(nd));
        write_reg(CFG_LRATE, 16'(lr));
        layers = lc < 2 ? 2 : (lc > 4 ? 4 : lc);
        cnt[0] = clamp_n(ni & 31);
        cnt[1] = clamp_n(na & 31);
        cnt[2] = clamp_n(nb & 31);
        cnt[3] = clamp_n(nd & 31);
        settings++;
    endtask

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    function automatic logic [15:0] rand_feature();
        case ($urandom_range(0, 7))
            0:       return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32767)) - 16384);
        endcase
    endfunction

    // Fill every weight and bias the current shape reads
    task automatic load_network();
        for (int l = 0; l < layers - 1; l++)
            for (int i = 0; i < cnt[l] * cnt[l+1]; i++)
                put(OP_LOAD_W, l, i, rand_weight(), $urandom_range(0, 15),
                    $urandom_range(0, 1));
        for (int l = 1; l < layers; l++)
            for (int j = 0; j < cnt[l]; j++)
                put(OP_LOAD_B, l, j, rand_weight(), $urandom_range(0, 15), 1'b0);
    endtask

    function automatic t_op rand_feature_op();
        return $urandom_range(0, 1) ? OP_TRAIN : OP_PREDICT;
    endfunction

    // One sample, mostly well formed, sometimes with noise or cut short
    task automatic send_sample();
        int label, n;
        label = $urandom_range(0, 7) == 0 ? $urandom_range(0, 15)
                                          : $urandom_range(0, cnt[layers-1] - 1);
        n = $urandom_range(0, 9) == 0 ? $urandom_range(1, cnt[0]) : cnt[0];
        for (int s = 0; s < n; s++) begin
            case ($urandom_range(0, 15))
                0: put(OP_LOAD_W, 3, $urandom_range(0, 255), 16'($urandom), 0, 1'b1);
                1: put(OP_LOAD_B, $urandom_range(0, 3), $urandom_range(16, 255),
                       16'($urandom), 0, 1'b0);
                2: put(rand_feature_op(), $urandom_range(0, 3),
                       $urandom_range(cnt[0], 255), 16'($urandom), label, 1'b0);
                default: ;
            endcase
            put(rand_feature_op(), $urandom_range(0, 3), s, rand_feature(), label,
                s == n - 1);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOAD_W;
        in_ch.layer_sel = '0;
        in_ch.slot = '0;
        in_ch.value = '0;
        in_ch.label = '0;
        in_ch.last = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_LAYER_COUNT;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        requests = 0;
        settings = 1;
        burst_left = 0;
        layers = 3;
        cnt = '{4, 8, 3, 3};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset shape, extremes and corner requests
        load_network();
        put(OP_PREDICT, 0, 0, 16'h8000, 0, 1'b0);
        put(OP_PREDICT, 0, 1, 16'h7fff, 0, 1'b0);
        put(OP_PREDICT, 0, 2, 16'h0000, 0, 1'b0);
        put(OP_PREDICT, 0, 3, 16'hffff, 2, 1'b1);
        put(OP_LOAD_W, 3, 255, 16'h1234, 15, 1'b1);
        put(OP_LOAD_B, 2, 200, 16'h4321, 0, 1'b0);
        put(OP_TRAIN, 0, 255, 16'h7fff, 15, 1'b0);
        put(OP_TRAIN, 0, 0, 16'h7fff, 15, 1'b0);
        put(OP_TRAIN, 0, 3, 16'h8000, 15, 1'b1);
        put(OP_PREDICT, 0, 1, 16'h1000, 1, 1'b0);
        put(OP_TRAIN, 0, 2, 16'hf000, 1, 1'b1);
        put(OP_TRAIN, 0, 0, 16'h0800, 0, 1'b1);
        put(OP_PREDICT, 0, 254, 16'h0000, 0, 1'b1);
        drain();

        // Extremes of the registers
        configure(2, 1, 1, 1, 1, 0);
        load_network();
        repeat (10) send_sample();
        configure(4, 16, 16, 16, 16, 65535);
        load_network();
        repeat (3) send_sample();
        configure(0, 0, 31, 17, 0, 40000);
        load_network();
        repeat (10) send_sample();
        configure(7, 2, 3, 2, 4, 1);
        load_network();
        repeat (10) send_sample();

        // Random shapes, mostly small
        while (requests < 1200) begin
            configure($urandom_range(0, 7),
                      $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 6),
                      $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 6),
                      $urandom_range(1, 6), $urandom_range(1, 6), $urandom);
            load_network();
            repeat ($urandom_range(20, 50)) begin
                send_sample();
                if ($urandom_range(0, 19) == 0) drain();
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("Covered %0d requests and %0d classifications over %0d register settings",
                 requests, results, settings);
        $display("including train and predict passes of two to four layers");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
